// ----- sv/pffl_pkg.sv -----
// ----------------------------------------------------------------------------
// pffl_pkg: shared definitions of the page frame allocator
// Field widths, command and register codes, status codes and the state types
// used by the front end, the queue and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package pffl_pkg;

  // Default values of the top-level parameters.
  localparam int unsigned MAX_PAGES_DEF  = 1024;
  localparam int unsigned PAGE_BYTES_DEF = 4096;
  localparam int unsigned DESC_BYTES_DEF = 8;
  localparam int unsigned ADDR_BITS_DEF  = 32;

  // Fixed widths of the port fields.
  localparam int unsigned CMD_W        = 2;
  localparam int unsigned FIELD_ADDR_W = 32;
  localparam int unsigned STATUS_W     = 3;
  localparam int unsigned COUNT_W      = 11;
  localparam int unsigned CFG_DATA_W   = 32;
  localparam int unsigned CFG_IDX_W    = 1;

  // Depth of the command queue between front and back end.
  localparam int unsigned Q_DEPTH = 2;

  // Command codes on in_cmd.
  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_INIT  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_BASE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PAGES = 1'b1;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_ALLOC    = 3'd0,
    ST_FREED    = 3'd1,
    ST_NOPAGE   = 3'd2,
    ST_NULL     = 3'd3,
    ST_RANGE    = 3'd4,
    ST_MISALIGN = 3'd5,
    ST_DOUBLE   = 3'd6,
    ST_INIT     = 3'd7
  } status_t;

  // Operations handed from the front end to the back end.
  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_INIT  = 2'd2,
    OP_REPLY = 2'd3
  } op_t;

  // Classified command as it travels through the queue.
  typedef struct packed {
    op_t     op;
    status_t status;
  } q_cmd_t;

  localparam int unsigned Q_CMD_W = $bits(q_cmd_t);

  // Front end sequencer states.
  typedef enum logic [1:0] {
    F_IDLE  = 2'd0,
    F_CLASS = 2'd1,
    F_DIV   = 2'd2
  } front_state_t;

  // Back end sequencer states.
  typedef enum logic [1:0] {
    B_IDLE  = 2'd0,
    B_EXEC  = 2'd1,
    B_INIT  = 2'd2,
    B_REPLY = 2'd3
  } back_state_t;

endpackage

`default_nettype wire

// ----- sv/pffl_front.sv -----
// ----------------------------------------------------------------------------
// pffl_front: command front end of the page frame allocator
// Latches an accepted command, checks a free address (null, range, alignment)
// and works out its page index, then pushes the classified command.
// ----------------------------------------------------------------------------
`default_nettype none

module pffl_front
  import pffl_pkg::*;
#(
  parameter int unsigned ADDR_BITS  = ADDR_BITS_DEF,
  parameter int unsigned PAGE_BYTES = PAGE_BYTES_DEF,
  parameter int unsigned MAX_PAGES  = MAX_PAGES_DEF,
  localparam int unsigned PG_W  = $clog2(MAX_PAGES + 1),
  localparam int unsigned IDX_W = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1,
  localparam int unsigned PB_W  = $clog2(PAGE_BYTES + 1),
  localparam int unsigned LIM_W = PG_W + PB_W
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    accept,
  input  wire logic [CMD_W-1:0]        cmd,
  input  wire logic [FIELD_ADDR_W-1:0] address,
  input  wire logic [ADDR_BITS-1:0]    act_base,
  input  wire logic [LIM_W-1:0]        act_limit,
  input  wire logic                    q_full,
  output logic                         busy,
  output logic                         push,
  output q_cmd_t                       push_cmd,
  output logic [IDX_W-1:0]             push_idx
);

  localparam int unsigned DW       = (ADDR_BITS > LIM_W) ? ADDR_BITS : LIM_W;
  localparam int unsigned SW       = 2;
  localparam int unsigned PB_SHIFT = $clog2(PAGE_BYTES);
  localparam bit          PB_POW2  = ((PAGE_BYTES & (PAGE_BYTES - 1)) == 0);

  // Reciprocal of the page size: the offset is cut to its top A_W bits and
  // multiplied by floor(2^(FL+A_W) / PAGE_BYTES).
  localparam int unsigned FL    = $clog2(PAGE_BYTES + 1) - 1;
  localparam int unsigned A_W   = PG_W + 1;
  localparam int unsigned RCP_W = A_W + 1;
  localparam int unsigned PR_W  = A_W + RCP_W;
  localparam logic [RCP_W-1:0] RCP_C =
    RCP_W'((64'd1 << (FL + A_W)) / 64'(PAGE_BYTES));

  // Steps of the page index calculation.
  localparam logic [SW-1:0] DIV_EST = 2'd0;
  localparam logic [SW-1:0] DIV_REM = 2'd1;
  localparam logic [SW-1:0] DIV_FIX = 2'd2;

  front_state_t            state_r, state_nxt;
  logic [CMD_W-1:0]        cmd_r;
  logic [ADDR_BITS-1:0]    addr_r;
  logic [DW-1:0]           rem_r, rem_nxt;
  logic [IDX_W-1:0]        quo_r, quo_nxt;
  logic [SW-1:0]           step_r, step_nxt;

  logic [ADDR_BITS+FIELD_ADDR_W-1:0] addr_ext;
  logic [ADDR_BITS-1:0]    addr_in;
  logic [ADDR_BITS-1:0]    off;
  logic                    is_null, is_below, is_over, pow2_mis;
  logic [IDX_W-1:0]        pow2_idx;
  logic [A_W-1:0]          div_hi;
  logic [PR_W-1:0]         div_prod;
  logic [IDX_W-1:0]        quo_est;
  logic [LIM_W-1:0]        quo_bytes;

  // The address field is taken modulo the internal address width.
  assign addr_ext = {{ADDR_BITS{1'b0}}, address};
  assign addr_in  = addr_ext[ADDR_BITS-1:0];

  // Checks on the latched free address.
  assign off      = addr_r - act_base;
  assign is_null  = (addr_r == '0);
  assign is_below = (addr_r < act_base);
  assign is_over  = (DW'(off) >= DW'(act_limit));
  assign pow2_idx = IDX_W'(off >> PB_SHIFT);
  assign pow2_mis = ((off & ADDR_BITS'(PAGE_BYTES - 1)) != '0);

  // Page index estimate, low by at most two, and the bytes it covers.
  assign div_hi    = A_W'(rem_r >> FL);
  assign div_prod  = PR_W'(div_hi) * PR_W'(RCP_C);
  assign quo_est   = IDX_W'(div_prod >> A_W);
  assign quo_bytes = LIM_W'(quo_r) * LIM_W'(PAGE_BYTES);

  // Sequencer: classify, divide where needed, push.
  always_comb begin
    state_nxt       = state_r;
    rem_nxt         = rem_r;
    quo_nxt         = quo_r;
    step_nxt        = step_r;
    push            = 1'b0;
    push_cmd.op     = OP_REPLY;
    push_cmd.status = ST_NOPAGE;
    push_idx        = '0;
    case (state_r)
      F_IDLE: begin
        if (accept) begin
          state_nxt = F_CLASS;
        end
      end
      F_CLASS: begin
        if (!q_full) begin
          state_nxt = F_IDLE;
          case (cmd_r)
            CMD_ALLOC: begin
              push        = 1'b1;
              push_cmd.op = OP_ALLOC;
            end
            CMD_INIT: begin
              push        = 1'b1;
              push_cmd.op = OP_INIT;
            end
            CMD_FREE: begin
              if (is_null) begin
                push            = 1'b1;
                push_cmd.status = ST_NULL;
              end else if (is_below || is_over) begin
                push            = 1'b1;
                push_cmd.status = ST_RANGE;
              end else if (PB_POW2) begin
                push = 1'b1;
                if (pow2_mis) begin
                  push_cmd.status = ST_MISALIGN;
                end else begin
                  push_cmd.op = OP_FREE;
                  push_idx    = pow2_idx;
                end
              end else begin
                state_nxt = F_DIV;
                rem_nxt   = DW'(off);
                step_nxt  = DIV_EST;
              end
            end
            default: begin
              push = 1'b1;
            end
          endcase
        end
      end
      F_DIV: begin
        case (step_r)
          DIV_EST: begin
            quo_nxt  = quo_est;
            step_nxt = DIV_REM;
          end
          DIV_REM: begin
            rem_nxt  = rem_r - DW'(quo_bytes);
            step_nxt = DIV_FIX;
          end
          default: begin
            // Put the estimate right one page at a time, then push.
            if (rem_r >= DW'(PAGE_BYTES)) begin
              rem_nxt = rem_r - DW'(PAGE_BYTES);
              quo_nxt = quo_r + IDX_W'(1);
            end else if (!q_full) begin
              push      = 1'b1;
              state_nxt = F_IDLE;
              if (rem_r != '0) begin
                push_cmd.status = ST_MISALIGN;
              end else begin
                push_cmd.op = OP_FREE;
                push_idx    = quo_r;
              end
            end
          end
        endcase
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Command latch and divider registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r  <= cmd;
      addr_r <= addr_in;
    end
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    step_r <= step_nxt;
  end

  assign busy = (state_r != F_IDLE);

endmodule

`default_nettype wire

// ----- sv/pffl_queue.sv -----
// ----------------------------------------------------------------------------
// pffl_queue: short command queue
// A small first-in first-out buffer that parts the front end from the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module pffl_queue
  import pffl_pkg::*;
#(
  parameter int unsigned WIDTH = Q_CMD_W,
  parameter int unsigned DEPTH = Q_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] pop_data,
  output logic                  empty,
  output logic                  full
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign empty   = (count_r == '0);
  assign full    = (count_r == CW'(DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + CW'(1);
      2'b01:   count_nxt = count_r - CW'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign pop_data = mem_r[rd_ptr_r];

endmodule

`default_nettype wire

// ----- sv/pffl_back.sv -----
// ----------------------------------------------------------------------------
// pffl_back: free list back end of the page frame allocator
// Holds the link and free-flag memories and the list state, carries out
// alloc, free and init, and drives the result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module pffl_back
  import pffl_pkg::*;
#(
  parameter int unsigned ADDR_BITS  = ADDR_BITS_DEF,
  parameter int unsigned PAGE_BYTES = PAGE_BYTES_DEF,
  parameter int unsigned DESC_BYTES = DESC_BYTES_DEF,
  parameter int unsigned MAX_PAGES  = MAX_PAGES_DEF,
  localparam int unsigned PG_W  = $clog2(MAX_PAGES + 1),
  localparam int unsigned IDX_W = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1,
  localparam int unsigned PB_W  = $clog2(PAGE_BYTES + 1),
  localparam int unsigned LIM_W = PG_W + PB_W
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    q_empty,
  input  wire q_cmd_t                  q_cmd,
  input  wire logic [IDX_W-1:0]        q_idx,
  output logic                         pop,
  input  wire logic [CFG_DATA_W-1:0]   cfg_base,
  input  wire logic [COUNT_W-1:0]      cfg_pages,
  output logic [ADDR_BITS-1:0]         act_base,
  output logic [LIM_W-1:0]             act_limit,
  output logic                         busy,
  output logic                         out_strobe,
  output status_t                      out_status,
  output logic [FIELD_ADDR_W-1:0]      out_page_address,
  output logic [COUNT_W-1:0]           out_free_count,
  output logic [COUNT_W-1:0]           out_used_count
);

  localparam int unsigned NEED_W = PG_W + $clog2(DESC_BYTES + 1);
  localparam int unsigned ACC_W  = LIM_W;
  localparam int unsigned RC_W   = (ACC_W > NEED_W) ? ACC_W : NEED_W;
  localparam int unsigned SAT_W  = (PG_W > COUNT_W) ? PG_W : COUNT_W;

  // Link and free-flag memories.
  logic [IDX_W-1:0] link_mem [MAX_PAGES];
  logic             flag_mem [MAX_PAGES];
  logic [IDX_W-1:0] link_q;
  logic             flag_q;

  back_state_t          state_r, state_nxt;
  op_t                  cur_op_r, cur_op_nxt;
  logic [IDX_W-1:0]     head_r, head_nxt;
  logic [PG_W-1:0]      free_r, free_nxt;
  logic [PG_W-1:0]      pages_r, pages_nxt;
  logic [ADDR_BITS-1:0] base_r, base_nxt;
  logic [LIM_W-1:0]     limit_r, limit_nxt;
  logic [NEED_W-1:0]    need_r, need_nxt;
  logic [ACC_W-1:0]     acc_r, acc_nxt;
  logic [PG_W-1:0]      sweep_r, sweep_nxt;
  logic                 found_r, found_nxt;
  status_t              rep_status_r, rep_status_nxt;
  logic [IDX_W-1:0]     rep_idx_r, rep_idx_nxt;
  logic                 out_strobe_r, out_strobe_nxt;
  status_t              out_status_r;
  logic [FIELD_ADDR_W-1:0] out_page_r;
  logic [COUNT_W-1:0]   out_free_r, out_used_r;

  logic                 link_re, flag_re;
  logic                 link_we, flag_we;
  logic [IDX_W-1:0]     link_waddr, flag_waddr;
  logic [IDX_W-1:0]     link_wdata;
  logic                 flag_wdata;

  logic [SAT_W-1:0]     cfg_pages_ext, pages_sat;
  logic [PG_W-1:0]      pages_in;
  logic [ADDR_BITS+CFG_DATA_W-1:0] base_ext;
  logic [PG_W-1:0]      sweep_inc;
  logic                 in_region, is_rsv, is_free;
  logic [IDX_W-1:0]     sweep_idx;
  logic [LIM_W-1:0]     page_off;
  logic [ADDR_BITS-1:0] page_addr;
  logic [ADDR_BITS+FIELD_ADDR_W-1:0] page_ext;
  logic [PG_W-1:0]      used_cnt;
  logic [PG_W+COUNT_W-1:0] free_ext, used_ext;

  // Register values taken at init: page count saturated, base masked.
  assign cfg_pages_ext = SAT_W'(cfg_pages);
  assign pages_sat     = (cfg_pages_ext > SAT_W'(MAX_PAGES)) ? SAT_W'(MAX_PAGES) : cfg_pages_ext;
  assign pages_in      = PG_W'(pages_sat);
  assign base_ext      = {{ADDR_BITS{1'b0}}, cfg_base};

  // Build pass: entry i is reserved while i*PAGE_BYTES < pages*DESC_BYTES.
  assign sweep_idx = sweep_r[IDX_W-1:0];
  assign sweep_inc = sweep_r + PG_W'(1);
  assign in_region = (sweep_r < pages_r);
  assign is_rsv    = (RC_W'(acc_r) < RC_W'(need_r));
  assign is_free   = in_region && !is_rsv;

  // Result values from the updated list state.
  assign page_off = LIM_W'(rep_idx_r) * LIM_W'(PAGE_BYTES);
  assign page_addr = base_r + ADDR_BITS'(page_off);
  assign page_ext  = {{FIELD_ADDR_W{1'b0}}, page_addr};
  assign used_cnt  = pages_r - free_r;
  assign free_ext  = {{COUNT_W{1'b0}}, free_r};
  assign used_ext  = {{COUNT_W{1'b0}}, used_cnt};

  // Sequencer: pop, execute, build the list, reply.
  always_comb begin
    state_nxt      = state_r;
    cur_op_nxt     = cur_op_r;
    head_nxt       = head_r;
    free_nxt       = free_r;
    pages_nxt      = pages_r;
    base_nxt       = base_r;
    limit_nxt      = limit_r;
    need_nxt       = need_r;
    acc_nxt        = acc_r;
    sweep_nxt      = sweep_r;
    found_nxt      = found_r;
    rep_status_nxt = rep_status_r;
    rep_idx_nxt    = rep_idx_r;
    out_strobe_nxt = 1'b0;
    pop            = 1'b0;
    link_re        = 1'b0;
    flag_re        = 1'b0;
    link_we        = 1'b0;
    flag_we        = 1'b0;
    link_waddr     = sweep_idx;
    flag_waddr     = sweep_idx;
    link_wdata     = '0;
    flag_wdata     = 1'b0;
    case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          pop        = 1'b1;
          cur_op_nxt = q_cmd.op;
          case (q_cmd.op)
            OP_ALLOC: begin
              if (free_r == '0) begin
                rep_status_nxt = ST_NOPAGE;
                state_nxt      = B_REPLY;
              end else begin
                link_re     = 1'b1;
                rep_idx_nxt = head_r;
                state_nxt   = B_EXEC;
              end
            end
            OP_FREE: begin
              flag_re     = 1'b1;
              rep_idx_nxt = q_idx;
              state_nxt   = B_EXEC;
            end
            OP_INIT: begin
              pages_nxt = pages_in;
              base_nxt  = base_ext[ADDR_BITS-1:0];
              limit_nxt = LIM_W'(pages_in) * LIM_W'(PAGE_BYTES);
              need_nxt  = NEED_W'(pages_in) * NEED_W'(DESC_BYTES);
              acc_nxt   = '0;
              sweep_nxt = '0;
              free_nxt  = '0;
              found_nxt = 1'b0;
              state_nxt = B_INIT;
            end
            default: begin
              rep_status_nxt = q_cmd.status;
              state_nxt      = B_REPLY;
            end
          endcase
        end
      end
      B_EXEC: begin
        state_nxt = B_REPLY;
        case (cur_op_r)
          OP_ALLOC: begin
            flag_we        = 1'b1;
            flag_waddr     = rep_idx_r;
            flag_wdata     = 1'b0;
            head_nxt       = link_q;
            free_nxt       = free_r - PG_W'(1);
            rep_status_nxt = ST_ALLOC;
          end
          OP_FREE: begin
            if (flag_q) begin
              rep_status_nxt = ST_DOUBLE;
            end else begin
              flag_we        = 1'b1;
              flag_waddr     = rep_idx_r;
              flag_wdata     = 1'b1;
              link_we        = 1'b1;
              link_waddr     = rep_idx_r;
              link_wdata     = head_r;
              head_nxt       = rep_idx_r;
              free_nxt       = free_r + PG_W'(1);
              rep_status_nxt = ST_FREED;
            end
          end
          default: begin
            rep_status_nxt = ST_NOPAGE;
          end
        endcase
      end
      B_INIT: begin
        flag_we    = 1'b1;
        flag_wdata = is_free;
        link_we    = 1'b1;
        link_wdata = (sweep_inc < pages_r) ? sweep_inc[IDX_W-1:0] : '0;
        acc_nxt    = acc_r + ACC_W'(PAGE_BYTES);
        sweep_nxt  = sweep_inc;
        if (is_free) begin
          free_nxt = free_r + PG_W'(1);
          if (!found_r) begin
            head_nxt  = sweep_idx;
            found_nxt = 1'b1;
          end
        end
        if (sweep_r == PG_W'(MAX_PAGES - 1)) begin
          rep_status_nxt = ST_INIT;
          state_nxt      = B_REPLY;
        end
      end
      B_REPLY: begin
        out_strobe_nxt = 1'b1;
        state_nxt      = B_IDLE;
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= B_IDLE;
      head_r       <= '0;
      free_r       <= '0;
      pages_r      <= '0;
      base_r       <= '0;
      limit_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      head_r       <= head_nxt;
      free_r       <= free_nxt;
      pages_r      <= pages_nxt;
      base_r       <= base_nxt;
      limit_r      <= limit_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  // Working registers of the current command.
  always_ff @(posedge clk) begin
    cur_op_r     <= cur_op_nxt;
    need_r       <= need_nxt;
    acc_r        <= acc_nxt;
    sweep_r      <= sweep_nxt;
    found_r      <= found_nxt;
    rep_status_r <= rep_status_nxt;
    rep_idx_r    <= rep_idx_nxt;
  end

  // Result registers, loaded in the reply cycle.
  always_ff @(posedge clk) begin
    if (state_r == B_REPLY) begin
      out_status_r <= rep_status_r;
      out_page_r   <= (rep_status_r == ST_ALLOC) ? page_ext[FIELD_ADDR_W-1:0] : '0;
      out_free_r   <= free_ext[COUNT_W-1:0];
      out_used_r   <= used_ext[COUNT_W-1:0];
    end
  end

  // Link memory with registered read.
  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    if (link_re) begin
      link_q <= link_mem[head_r];
    end
  end

  // Free-flag memory with registered read.
  always_ff @(posedge clk) begin
    if (flag_we) begin
      flag_mem[flag_waddr] <= flag_wdata;
    end
    if (flag_re) begin
      flag_q <= flag_mem[q_idx];
    end
  end

  assign act_base         = base_r;
  assign act_limit        = limit_r;
  assign busy             = (state_r != B_IDLE);
  assign out_strobe       = out_strobe_r;
  assign out_status       = out_status_r;
  assign out_page_address = out_page_r;
  assign out_free_count   = out_free_r;
  assign out_used_count   = out_used_r;

endmodule

`default_nettype wire

// ----- sv/page_frame_free_list_allocator_top.sv -----
// ----------------------------------------------------------------------------
// page_frame_free_list_allocator_top: free list page frame allocator
// Configuration registers, front end, command queue and free list back end.
// ----------------------------------------------------------------------------
// One command is in flight at a time: busy rises after start is taken and
// falls in the cycle in which the result beat is shown on out_strobe, so a new
// start may be taken in that same cycle. An alloc or a free that reaches the
// free list passes through the latch and classify step, the queue hand-over
// with one registered read of the link or free-flag memory, the write back,
// loading the result registers and the result beat itself. A rejected free,
// an alloc with no page left and an unused command skip the write back.
// When PAGE_BYTES is not a power of two a free in range also passes through
// the front end divider, where the page index is estimated with a reciprocal
// multiply and then put right by up to two subtractions. Init rebuilds both
// memories in one pass over all MAX_PAGES entries, one entry a cycle. The
// receiver cannot stall: each result beat is shown for exactly one cycle.
`default_nettype none

module page_frame_free_list_allocator_top
  import pffl_pkg::*;
#(
  parameter int unsigned MAX_PAGES  = MAX_PAGES_DEF,
  parameter int unsigned PAGE_BYTES = PAGE_BYTES_DEF,
  parameter int unsigned DESC_BYTES = DESC_BYTES_DEF,
  parameter int unsigned ADDR_BITS  = ADDR_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic [CMD_W-1:0]        in_cmd,
  input  wire logic [FIELD_ADDR_W-1:0] in_address,
  output logic                         out_strobe,
  output logic [STATUS_W-1:0]          out_status,
  output logic [FIELD_ADDR_W-1:0]      out_page_address,
  output logic [COUNT_W-1:0]           out_free_count,
  output logic [COUNT_W-1:0]           out_used_count,
  input  wire logic                    cfg_we,
  input  wire logic [CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int unsigned PG_W  = $clog2(MAX_PAGES + 1);
  localparam int unsigned IDX_W = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int unsigned PB_W  = $clog2(PAGE_BYTES + 1);
  localparam int unsigned LIM_W = PG_W + PB_W;
  localparam int unsigned QW    = Q_CMD_W + IDX_W;

  logic [CFG_DATA_W-1:0] base_cfg_r;
  logic [COUNT_W-1:0]    pages_cfg_r;

  logic                  accept;
  logic                  front_busy, back_busy;
  logic                  push, pop, q_empty, q_full;
  q_cmd_t                push_cmd, q_cmd;
  logic [IDX_W-1:0]      push_idx, q_idx;
  logic [QW-1:0]         push_data, pop_data;
  logic [ADDR_BITS-1:0]  act_base;
  logic [LIM_W-1:0]      act_limit;
  status_t               back_status;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_cfg_r  <= '0;
      pages_cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BASE:  base_cfg_r  <= cfg_wdata;
        REG_PAGES: pages_cfg_r <= cfg_wdata[COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Command beat handshake.
  assign accept = start && !busy;
  assign busy   = front_busy || !q_empty || back_busy;

  pffl_front #(
    .ADDR_BITS  (ADDR_BITS),
    .PAGE_BYTES (PAGE_BYTES),
    .MAX_PAGES  (MAX_PAGES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .cmd       (in_cmd),
    .address   (in_address),
    .act_base  (act_base),
    .act_limit (act_limit),
    .q_full    (q_full),
    .busy      (front_busy),
    .push      (push),
    .push_cmd  (push_cmd),
    .push_idx  (push_idx)
  );

  // Queue payload packing.
  assign push_data = {push_cmd, push_idx};
  assign q_cmd     = pop_data[IDX_W +: Q_CMD_W];
  assign q_idx     = pop_data[IDX_W-1:0];

  pffl_queue #(
    .WIDTH (QW),
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (q_empty),
    .full      (q_full)
  );

  pffl_back #(
    .ADDR_BITS  (ADDR_BITS),
    .PAGE_BYTES (PAGE_BYTES),
    .DESC_BYTES (DESC_BYTES),
    .MAX_PAGES  (MAX_PAGES)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_cmd            (q_cmd),
    .q_idx            (q_idx),
    .pop              (pop),
    .cfg_base         (base_cfg_r),
    .cfg_pages        (pages_cfg_r),
    .act_base         (act_base),
    .act_limit        (act_limit),
    .busy             (back_busy),
    .out_strobe       (out_strobe),
    .out_status       (back_status),
    .out_page_address (out_page_address),
    .out_free_count   (out_free_count),
    .out_used_count   (out_used_count)
  );

  assign out_status = back_status;

endmodule

`default_nettype wire

// ----- sv/pffl_checker.sv -----
// ----------------------------------------------------------------------------
// pffl_checker: port-level checks of the page frame allocator
// Watches the command and result ports over time; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pffl_checker
  import pffl_pkg::*;
(
  input wire logic                    clk,
  input wire logic                    rst_n,
  input wire logic                    start,
  input wire logic                    busy,
  input wire logic                    out_strobe,
  input wire logic [STATUS_W-1:0]     out_status,
  input wire logic [FIELD_ADDR_W-1:0] out_page_address
);

  // Reset leaves the block idle with no result beat.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (!busy && !out_strobe))
    else $error("block not idle after reset");

  // A taken command makes the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy did not rise after a command beat");

  // Only one command is in flight, so result beats never come back to back.
  a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("two result beats in a row");

  // The block is free again when its result is shown.
  a_idle_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("busy while a result beat is shown");

  // A page address is reported only with an allocation.
  a_page_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_status != ST_ALLOC)) |-> (out_page_address == '0))
    else $error("page address set on a result that is not an allocation");

endmodule

bind page_frame_free_list_allocator_top pffl_checker u_pffl_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_strobe       (out_strobe),
  .out_status       (out_status),
  .out_page_address (out_page_address)
);

`default_nettype wire

// ----- bench/tb_page_frame_free_list_allocator_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_page_frame_free_list_allocator_top: self-checking bench for the allocator
// Drives alloc, free, init and unused commands through the start/busy handshake and
// sets the region registers between phases. A shadow of the free list predicts
// every reply beat, and each beat is compared field by field on out_strobe.
// ----------------------------------------------------------------------------

module tb_page_frame_free_list_allocator_top;
  import pffl_pkg::*;

  localparam int unsigned PAGE_SZ     = PAGE_BYTES_DEF;
  localparam int unsigned MAXP        = MAX_PAGES_DEF;
  localparam int unsigned DESC_SZ     = DESC_BYTES_DEF;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  // One predicted reply beat.
  typedef struct {
    status_t                 status;
    logic [FIELD_ADDR_W-1:0] page_address;
    logic [COUNT_W-1:0]      free_count;
    logic [COUNT_W-1:0]      used_count;
  } reply_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  logic [CMD_W-1:0]        in_cmd = '0;
  logic [FIELD_ADDR_W-1:0] in_address = '0;
  logic                    out_strobe;
  logic [STATUS_W-1:0]     out_status;
  logic [FIELD_ADDR_W-1:0] out_page_address;
  logic [COUNT_W-1:0]      out_free_count;
  logic [COUNT_W-1:0]      out_used_count;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_wdata = '0;

  // Shadow of the allocator: registers, latched region and the free list.
  logic [31:0]     reg_base;
  logic [10:0]     reg_pages;
  logic [31:0]     cur_base;
  int unsigned     n_active;
  int unsigned     n_free;
  int unsigned     head_page;
  int unsigned     nxt_page [MAXP];
  bit              is_free [MAXP];

  reply_t          pending_replies [$];
  int              errors = 0;
  int              idle_pct = 33;
  int unsigned     cycles = 0;

  page_frame_free_list_allocator_top uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_cmd           (in_cmd),
    .in_address       (in_address),
    .out_strobe       (out_strobe),
    .out_status       (out_status),
    .out_page_address (out_page_address),
    .out_free_count   (out_free_count),
    .out_used_count   (out_used_count),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always #4 clk = ~clk;

  // Works out the reply to one accepted command and updates the shadow list.
  function automatic reply_t allocator_step(input logic [CMD_W-1:0] cmd,
                                            input logic [31:0] addr);
    reply_t          r;
    int unsigned     pages;
    int unsigned     rsv;
    int unsigned     idx;
    longint unsigned off;
    r.status       = ST_NOPAGE;
    r.page_address = '0;
    case (cmd)
      CMD_ALLOC: begin
        if (n_free > 0) begin
          idx          = head_page;
          head_page    = nxt_page[idx];
          is_free[idx] = 1'b0;
          n_free--;
          r.page_address = cur_base + 32'(idx) * 32'(PAGE_SZ);
          r.status       = ST_ALLOC;
        end
      end
      CMD_FREE: begin
        if (addr == '0) begin
          r.status = ST_NULL;
        end else if (addr < cur_base) begin
          r.status = ST_RANGE;
        end else begin
          off = 64'(addr - cur_base);
          if (off >= 64'(n_active) * 64'(PAGE_SZ)) begin
            r.status = ST_RANGE;
          end else if (off % PAGE_SZ != 0) begin
            r.status = ST_MISALIGN;
          end else begin
            idx = int'(off / PAGE_SZ);
            if (idx >= MAXP) begin
              r.status = ST_RANGE;
            end else if (is_free[idx]) begin
              r.status = ST_DOUBLE;
            end else begin
              is_free[idx]  = 1'b1;
              nxt_page[idx] = head_page;
              head_page     = idx;
              n_free++;
              r.status = ST_FREED;
            end
          end
        end
      end
      CMD_INIT: begin
        // Oversized regions saturate, and the descriptor pages never exceed the region.
        pages = (reg_pages > MAXP) ? MAXP : reg_pages;
        rsv   = (pages * DESC_SZ + PAGE_SZ - 1) / PAGE_SZ;
        if (rsv > pages) rsv = pages;
        for (int unsigned i = 0; i < MAXP; i++) begin
          is_free[i]  = (i < pages) && (i >= rsv);
          nxt_page[i] = (i + 1 < pages) ? i + 1 : 0;
        end
        cur_base  = reg_base;
        n_active  = pages;
        n_free    = pages - rsv;
        head_page = (n_free > 0) ? rsv : 0;
        r.status  = ST_INIT;
      end
      default: ;
    endcase
    r.free_count = 11'(n_free);
    r.used_count = 11'(n_active - n_free);
    return r;
  endfunction

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
    end
  endtask

  // Checks each reply beat, then records register writes and accepted commands.
  always @(posedge clk) begin
    reply_t exp_reply;
    if (!rst_n) begin
      reg_base  = '0;
      reg_pages = '0;
      cur_base  = '0;
      n_active  = 0;
      n_free    = 0;
      head_page = 0;
      pending_replies.delete();
    end else begin
      if (out_strobe) begin
        if (pending_replies.size() == 0) begin
          errors++;
          $display("%0t: reply beat with none expected, got status %0d", $time, out_status);
        end else begin
          exp_reply = pending_replies.pop_front();
          check_field("status", 32'(exp_reply.status), 32'(out_status));
          check_field("page_address", exp_reply.page_address, out_page_address);
          check_field("free_count", 32'(exp_reply.free_count), 32'(out_free_count));
          check_field("used_count", 32'(exp_reply.used_count), 32'(out_used_count));
        end
      end
      if (cfg_we) begin
        if (cfg_index == REG_BASE) reg_base = cfg_wdata;
        else reg_pages = cfg_wdata[10:0];
      end
      if (start && !busy) pending_replies.push_back(allocator_step(in_cmd, in_address));
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL page_frame_free_list_allocator_top");
      $finish;
    end
  end

  // Offers one command beat, at times after a random gap, and waits until it is taken.
  task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [31:0] addr);
    int gap;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      gap   = $urandom_range(1, 9);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    in_cmd     <= cmd;
    in_address <= addr;
    do @(posedge clk); while (busy);
  endtask

  // Holds off new commands until every expected reply has come back.
  task automatic wait_for_replies();
    start <= 1'b0;
    do @(posedge clk); while (pending_replies.size() != 0);
  endtask

  // Writes both region registers; only called while the block is idle.
  task automatic set_region(input logic [31:0] base, input int unsigned pages);
    cfg_we    <= 1'b1;
    cfg_index <= REG_BASE;
    cfg_wdata <= base;
    @(posedge clk);
    cfg_index <= REG_PAGES;
    cfg_wdata <= 32'(pages);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Commands before any init find an empty region.
  task automatic test_before_init();
    send_cmd(CMD_ALLOC, 32'hFFFF_FFFF);
    send_cmd(CMD_FREE, 32'h0000_0000);
    send_cmd(CMD_FREE, 32'h0000_1000);
    send_cmd(CMD_UNUSED, 32'hA5A5_5A5A);
  endtask

  // A three-page region at address zero: exhaustion and every free check.
  task automatic test_small_region();
    wait_for_replies();
    set_region(32'h0000_0000, 3);
    send_cmd(CMD_INIT, 32'h0);
    send_cmd(CMD_ALLOC, 32'h0);
    send_cmd(CMD_ALLOC, 32'h0);
    send_cmd(CMD_ALLOC, 32'h0);
    send_cmd(CMD_FREE, 32'h0000_0000);
    send_cmd(CMD_FREE, 32'h0000_1800);
    send_cmd(CMD_FREE, 32'h0000_3000);
    send_cmd(CMD_FREE, 32'h0000_1000);
    send_cmd(CMD_FREE, 32'h0000_1000);
  endtask

  // A descriptor page is marked used, so freeing it puts it on the list.
  task automatic test_reserved_page_free();
    wait_for_replies();
    set_region(32'h8000_0000, 5);
    send_cmd(CMD_INIT, 32'h0);
    send_cmd(CMD_FREE, 32'h8000_0000);
    send_cmd(CMD_ALLOC, 32'h0);
  endtask

  // Oversized, descriptor-only and empty regions.
  task automatic test_region_limits();
    wait_for_replies();
    set_region(32'h1234_5000, 2047);
    send_cmd(CMD_INIT, 32'h0);
    send_cmd(CMD_FREE, 32'h1234_5000 + 32'(MAXP * PAGE_SZ));
    send_cmd(CMD_ALLOC, 32'h0);
    wait_for_replies();
    set_region(32'h1234_5000, 1);
    send_cmd(CMD_INIT, 32'h0);
    wait_for_replies();
    set_region(32'h1234_5000, 0);
    send_cmd(CMD_INIT, 32'h0);
    send_cmd(CMD_FREE, 32'h1234_5000);
  endtask

  // A region at the top of the address space wraps, and a second init drops it all.
  task automatic test_top_of_address_space();
    wait_for_replies();
    set_region(32'hFFFF_F000, 3);
    send_cmd(CMD_INIT, 32'h0);
    send_cmd(CMD_ALLOC, 32'h0);
    send_cmd(CMD_FREE, 32'hFFFF_FFFF);
    send_cmd(CMD_INIT, 32'h0);
    send_cmd(CMD_ALLOC, 32'h0);
  endtask

  // Random regions, each with a run of commands, mostly allocs and low-page frees.
  task automatic test_random_traffic(input int pct, input int n_items);
    int          sent;
    int          pick;
    int          run_len;
    int          alloc_pct;
    int unsigned pages;
    int unsigned span;
    int unsigned idx;
    logic [31:0] base;
    idle_pct = pct;
    sent     = 0;
    while (sent < n_items) begin
      wait_for_replies();
      pick = $urandom_range(9);
      if (pick == 6) base = 32'h0000_0000;
      else if (pick == 7) base = $urandom;
      else if (pick == 8) base = 32'hFFFF_0000 | ($urandom & 32'h0000_F000);
      else base = $urandom & 32'hFFFF_F000;
      pick = $urandom_range(19);
      if (pick < 13) pages = $urandom_range(0, 40);
      else if (pick < 17) pages = $urandom_range(41, 700);
      else if (pick == 17) pages = MAXP;
      else pages = $urandom_range(MAXP + 1, 2047);
      span = (pages > MAXP) ? MAXP : pages;
      set_region(base, pages);
      send_cmd(CMD_INIT, $urandom);
      sent++;
      run_len   = $urandom_range(8, 40);
      alloc_pct = $urandom_range(25, 65);
      repeat (run_len) begin
        idx = (span > 48 && $urandom_range(3) != 0) ? $urandom_range(0, 48)
                                                    : $urandom_range(0, span);
        pick = $urandom_range(99);
        if (pick < alloc_pct) begin
          send_cmd(CMD_ALLOC, $urandom);
        end else if (pick < 88) begin
          send_cmd(CMD_FREE, base + 32'(idx) * 32'(PAGE_SZ));
        end else if (pick < 92) begin
          send_cmd(CMD_FREE, base + 32'(idx) * 32'(PAGE_SZ) + $urandom_range(1, PAGE_SZ - 1));
        end else if (pick < 95) begin
          send_cmd(CMD_FREE, $urandom);
        end else if (pick < 97) begin
          send_cmd(CMD_FREE, 32'h0);
        end else if (pick < 99) begin
          send_cmd(CMD_UNUSED, $urandom);
        end else begin
          send_cmd(CMD_INIT, $urandom);
        end
        sent++;
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_before_init();
    test_small_region();
    test_reserved_page_free();
    test_region_limits();
    test_top_of_address_space();
    test_random_traffic(33, 400);
    test_random_traffic(57, 400);
    test_random_traffic(0, 400);
    wait_for_replies();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("PASS page_frame_free_list_allocator_top");
    end else begin
      $display("FAIL page_frame_free_list_allocator_top");
    end
    $finish;
  end

endmodule
